### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the segment allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a implies b on the same edge.
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// Check that a implies b on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

### hdl/vssa_pkg.sv
// ----------------------------------------------------------------------------
// vssa_pkg
// Types and codes shared by the segment allocator.
// ----------------------------------------------------------------------------
package vssa_pkg;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NO_HOLE = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_ZERO    = 3'd4;
	localparam logic [2:0] ST_UNINIT  = 3'd5;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_NEXT  = 2'd1;
	localparam logic [1:0] FIT_BEST  = 2'd2;
	localparam logic [1:0] FIT_WORST = 2'd3;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic CFG_ARENA  = 1'b0;
	localparam logic CFG_POLICY = 1'b1;

endpackage

### hdl/variable_size_segment_allocator.sv
// ----------------------------------------------------------------------------
// variable_size_segment_allocator
// Arena allocator keeping an address-ordered linked segment table in memory.
// ----------------------------------------------------------------------------
// An allocate walks the N list entries, a registered read per entry, and
//   scans the memory for a free entry unless the hole fits exactly; a free
//   scans for the segment, merges holes and relinks; zero size or uninit skip it.
// Throughput: one request at a time; start is taken again while done is high.
// Reset and every configuration write run a clearing pass over the segment
//   memory; start is not taken meanwhile. No stall.
module variable_size_segment_allocator
	import vssa_pkg::*;
#(
	parameter int MAX_SEGMENTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [31:0] alloc_size,
	input  logic [31:0] free_offset,
	output logic        done,
	output logic [31:0] result_offset,
	output logic [2:0]  status,
	output logic [10:0] segments_in_use,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
`include "assert_macros.svh"

	localparam int AW = $clog2(MAX_SEGMENTS);
	localparam int LW = AW + 1;
	localparam logic [LW-1:0] NIL = LW'(MAX_SEGMENTS);
	localparam logic [AW-1:0] LAST = AW'(MAX_SEGMENTS - 1);

	typedef struct packed {
		logic          valid;
		logic          hole;
		logic [31:0]   start;
		logic [31:0]   length;
		logic [LW-1:0] next;
		logic [LW-1:0] prev;
	} seg_t;

	typedef enum logic [21:0] {
		S_CLEAR  = 22'h000001,
		S_IDLE   = 22'h000002,
		S_RREAD  = 22'h000004,
		S_REVAL  = 22'h000008,
		S_WREAD  = 22'h000010,
		S_WEVAL  = 22'h000020,
		S_PICK   = 22'h000040,
		S_FREAD  = 22'h000080,
		S_FEVAL  = 22'h000100,
		S_EXACT  = 22'h000200,
		S_NEW    = 22'h000400,
		S_SHRINK = 22'h000800,
		S_XREAD  = 22'h001000,
		S_XEVAL  = 22'h002000,
		S_NREAD  = 22'h004000,
		S_NEVAL  = 22'h008000,
		S_BREAD  = 22'h010000,
		S_BEVAL  = 22'h020000,
		S_KILL   = 22'h040000,
		S_LREAD  = 22'h080000,
		S_LEVAL  = 22'h100000,
		S_DONE   = 22'h200000
	} state_t;

	// memory of segments: one write port, one registered read port
	seg_t          mem [MAX_SEGMENTS];
	logic          we;
	logic [AW-1:0] waddr;
	seg_t          wdata;
	logic [AW-1:0] raddr;
	seg_t          rd;

	state_t        state_q;
	logic [31:0]   arena_q;
	logic [1:0]    policy_q;
	logic [LW-1:0] head_q, rover_q;
	logic [10:0]   used_q;
	logic [32:0]   size_q;
	logic [31:0]   off_q;
	logic [LW-1:0] cur_q, first_q, pick_q, e_q, lnk_q, lval_q;
	logic          lsel_q;
	seg_t          h_q, b_q;
	logic [AW-1:0] cnt_q;
	logic [2:0]    st_q;
	logic [31:0]   roff_q;

	logic [32:0]   cfg_arena;
	logic          live_cur;
	logic          fits;
	logic [LW-1:0] nxt;
	seg_t          b_merged;
	seg_t          rd_freed;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd <= mem[raddr];
	end

	assign cfg_arena = {1'b0, cfg_data} + 33'd3;
	assign cfg_ready = (state_q == S_CLEAR) || ((state_q == S_IDLE) && !start);
	assign busy = state_q != S_IDLE;

	assign live_cur = (cur_q != NIL) && rd.valid;
	assign fits = live_cur && rd.hole && ({1'b0, rd.length} >= size_q);
	assign nxt = (rd.next == NIL) ? head_q : rd.next;

	always_comb begin
		b_merged = b_q;
		b_merged.length = b_q.length + rd.length;
		b_merged.next = rd.next;
		rd_freed = rd;
		rd_freed.hole = 1'b1;
	end

	always_comb begin
		raddr = cur_q[AW-1:0];
		we = 1'b0;
		waddr = cur_q[AW-1:0];
		wdata = rd;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				waddr = cnt_q;
				wdata = '0;
				if ((cnt_q == '0) && (arena_q != 32'd0))
					wdata = '{valid: 1'b1, hole: 1'b1, start: 32'd0, length: arena_q,
						next: NIL, prev: NIL};
			end
			S_RREAD: raddr = rover_q[AW-1:0];
			S_FREAD, S_XREAD: raddr = cnt_q;
			S_LREAD: raddr = lnk_q[AW-1:0];
			S_EXACT: begin
				we = 1'b1;
				waddr = pick_q[AW-1:0];
				wdata = h_q;
				wdata.hole = 1'b0;
			end
			S_NEW: begin
				we = 1'b1;
				waddr = e_q[AW-1:0];
				wdata = '{valid: 1'b1, hole: 1'b0, start: h_q.start,
					length: size_q[31:0], next: pick_q, prev: h_q.prev};
			end
			S_SHRINK: begin
				we = 1'b1;
				waddr = pick_q[AW-1:0];
				wdata = h_q;
				wdata.start = h_q.start + size_q[31:0];
				wdata.length = h_q.length - size_q[31:0];
				wdata.prev = e_q;
			end
			S_NEVAL: begin
				we = live_cur && rd.hole;
				wdata = rd;
				wdata.valid = 1'b0;
				wdata.hole = 1'b0;
			end
			S_BEVAL: begin
				we = 1'b1;
				if (live_cur && rd.hole) begin
					wdata = rd;
					wdata.length = rd.length + b_q.length;
					wdata.next = b_q.next;
				end else begin
					waddr = e_q[AW-1:0];
					wdata = b_q;
				end
			end
			S_KILL: begin
				we = 1'b1;
				waddr = e_q[AW-1:0];
				wdata = b_q;
				wdata.valid = 1'b0;
				wdata.hole = 1'b0;
			end
			S_LEVAL: begin
				we = 1'b1;
				waddr = lnk_q[AW-1:0];
				wdata = rd;
				if (lsel_q)
					wdata.next = lval_q;
				else
					wdata.prev = lval_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			arena_q <= 32'd65536;
			policy_q <= FIT_FIRST;
			cnt_q <= '0;
			head_q <= '0;
			rover_q <= '0;
			used_q <= 11'd1;
			done <= 1'b0;
			size_q <= '0;
			off_q <= '0;
			cur_q <= '0;
			first_q <= '0;
			pick_q <= NIL;
			e_q <= '0;
			lnk_q <= '0;
			lval_q <= '0;
			lsel_q <= 1'b0;
			h_q <= '0;
			b_q <= '0;
			st_q <= ST_OK;
			roff_q <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_ARENA)
					arena_q <= cfg_arena[32] ? 32'hFFFF_FFFC : {cfg_arena[31:2], 2'b00};
				else
					policy_q <= cfg_data[1:0];
				state_q <= S_CLEAR;
				cnt_q <= '0;
				head_q <= '0;
				rover_q <= '0;
			end else begin
				case (state_q)
					S_CLEAR: begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == LAST) begin
							state_q <= S_IDLE;
							used_q <= (arena_q != 32'd0) ? 11'd1 : 11'd0;
						end
					end
					S_IDLE: if (start) begin
						size_q <= ({1'b0, alloc_size} + 33'd3) & ~33'd3;
						off_q <= free_offset;
						roff_q <= 32'd0;
						pick_q <= NIL;
						cnt_q <= '0;
						st_q <= ST_OK;
						if (arena_q == 32'd0) begin
							st_q <= ST_UNINIT;
							state_q <= S_DONE;
						end else if (req_type == REQ_FREE) begin
							state_q <= S_XREAD;
						end else if (alloc_size == 32'd0) begin
							st_q <= ST_ZERO;
							state_q <= S_DONE;
						end else if (policy_q == FIT_NEXT) begin
							state_q <= S_RREAD;
						end else begin
							cur_q <= head_q;
							state_q <= S_WREAD;
						end
					end
					S_RREAD: state_q <= S_REVAL;
					S_REVAL: begin
						cur_q <= ((rover_q != NIL) && rd.valid) ? rover_q : head_q;
						first_q <= ((rover_q != NIL) && rd.valid) ? rover_q : head_q;
						state_q <= S_WREAD;
					end
					S_WREAD: state_q <= S_WEVAL;
					S_WEVAL: begin
						if (!live_cur) begin
							state_q <= S_PICK;
						end else if (policy_q == FIT_NEXT) begin
							if (fits) begin
								pick_q <= cur_q;
								h_q <= rd;
								state_q <= S_PICK;
							end else if (nxt == first_q) begin
								state_q <= S_PICK;
							end else begin
								cur_q <= nxt;
								state_q <= S_WREAD;
							end
						end else if (fits && (policy_q == FIT_FIRST)) begin
							pick_q <= cur_q;
							h_q <= rd;
							state_q <= S_PICK;
						end else begin
							if (fits && ((pick_q == NIL) ||
								((policy_q == FIT_BEST) && (rd.length < h_q.length)) ||
								((policy_q == FIT_WORST) && (rd.length > h_q.length)))) begin
								pick_q <= cur_q;
								h_q <= rd;
							end
							cur_q <= rd.next;
							state_q <= S_WREAD;
						end
					end
					S_PICK: begin
						if (pick_q == NIL) begin
							st_q <= ST_NO_HOLE;
							state_q <= S_DONE;
						end else if ({1'b0, h_q.length} == size_q) begin
							rover_q <= pick_q;
							roff_q <= h_q.start;
							state_q <= S_EXACT;
						end else begin
							cnt_q <= '0;
							state_q <= S_FREAD;
						end
					end
					S_FREAD: state_q <= S_FEVAL;
					S_FEVAL: begin
						if (!rd.valid) begin
							e_q <= {1'b0, cnt_q};
							state_q <= S_NEW;
						end else if (cnt_q == LAST) begin
							st_q <= ST_FULL;
							state_q <= S_DONE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
							state_q <= S_FREAD;
						end
					end
					S_EXACT: state_q <= S_DONE;
					S_NEW: state_q <= S_SHRINK;
					S_SHRINK: begin
						rover_q <= e_q;
						roff_q <= h_q.start;
						used_q <= used_q + 11'd1;
						if (h_q.prev == NIL) begin
							head_q <= e_q;
							state_q <= S_DONE;
						end else begin
							lnk_q <= h_q.prev;
							lval_q <= e_q;
							lsel_q <= 1'b1;
							state_q <= S_LREAD;
						end
					end
					S_XREAD: state_q <= S_XEVAL;
					S_XEVAL: begin
						if (rd.valid && !rd.hole && (rd.start == off_q)) begin
							e_q <= {1'b0, cnt_q};
							b_q <= rd_freed;
							cur_q <= rd.next;
							state_q <= S_NREAD;
						end else if (cnt_q == LAST) begin
							st_q <= ST_UNKNOWN;
							state_q <= S_DONE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
							state_q <= S_XREAD;
						end
					end
					S_NREAD: state_q <= S_NEVAL;
					S_NEVAL: begin
						// absorb next hole into freed entry
						if (live_cur && rd.hole) begin
							b_q <= b_merged;
							if (rover_q == cur_q)
								rover_q <= e_q;
							used_q <= used_q - 11'd1;
						end
						cur_q <= b_q.prev;
						state_q <= S_BREAD;
					end
					S_BREAD: state_q <= S_BEVAL;
					S_BEVAL: begin
						// absorb freed entry into previous hole
						if (live_cur && rd.hole) begin
							if (rover_q == e_q)
								rover_q <= cur_q;
							used_q <= used_q - 11'd1;
							state_q <= S_KILL;
						end else if (b_q.next != NIL) begin
							lnk_q <= b_q.next;
							lval_q <= e_q;
							lsel_q <= 1'b0;
							state_q <= S_LREAD;
						end else begin
							state_q <= S_DONE;
						end
					end
					S_KILL: begin
						if (b_q.next != NIL) begin
							lnk_q <= b_q.next;
							lval_q <= cur_q;
							lsel_q <= 1'b0;
							state_q <= S_LREAD;
						end else begin
							state_q <= S_DONE;
						end
					end
					S_LREAD: state_q <= S_LEVAL;
					S_LEVAL: state_q <= S_DONE;
					S_DONE: begin
						done <= 1'b1;
						state_q <= S_IDLE;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign result_offset = roff_q;
	assign status = st_q;
	assign segments_in_use = used_q;

	`ASSERT_IMPL(a_done_idle, clk, arst_n, done, state_q == S_IDLE)
	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_IMPL(a_used_max, clk, arst_n, 1'b1, used_q <= 11'(MAX_SEGMENTS))
	`ASSERT_IMPL(a_one_hot, clk, arst_n, 1'b1, $onehot(state_q))
	`ASSERT_NEXT(a_cfg_clear, clk, arst_n, cfg_valid && cfg_ready, state_q == S_CLEAR)

endmodule
